// ----- design/smm_pkg.sv -----
package smm_pkg;

	localparam int DIM_W   = 4;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 3;
	localparam int WORD_W  = 32;
	localparam int CODE_W  = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	localparam logic [CODE_W-1:0] CMD_WRITE_A = 2'd0;
	localparam logic [CODE_W-1:0] CMD_WRITE_B = 2'd1;
	localparam logic [CODE_W-1:0] CMD_QUERY   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             write_a;
		logic             write_b;
		logic             capture;
		logic             issue;
		logic [DIM_W-1:0] step;
		logic             load_result;
		logic             load_bad;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             index_ok;
		logic [DIM_W-1:0] dim_use;
	} dp_status_t;

endpackage

// ----- design/smm_datapath.sv -----
module smm_datapath #(
	parameter int MAX_DIM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dimension_we,
	input  logic [smm_pkg::DIM_W-1:0]   dimension,
	input  logic [smm_pkg::ROW_W-1:0]   row,
	input  logic [smm_pkg::COL_W-1:0]   col,
	input  logic signed [smm_pkg::WORD_W-1:0] value,
	input  smm_pkg::ctrl_cmd_t          cmd,
	output smm_pkg::dp_status_t         status,
	output logic signed [smm_pkg::WORD_W-1:0] product,
	output logic                        bad_index
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DIM_CAP_INT = (MAX_DIM > (2 ** smm_pkg::DIM_W) - 1) ?
		(2 ** smm_pkg::DIM_W) - 1 : MAX_DIM;
	localparam logic [smm_pkg::DIM_W-1:0] DIM_CAP = smm_pkg::DIM_W'(DIM_CAP_INT);

	logic [smm_pkg::DIM_W-1:0]  dim_q;
	logic [smm_pkg::DIM_W-1:0]  dim_use;
	logic [smm_pkg::ROW_W-1:0]  row_q;
	logic [smm_pkg::COL_W-1:0]  col_q;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr_a;
	logic [ADDR_W-1:0]          rd_addr_b;
	logic [smm_pkg::WORD_W-1:0] mem_a [DEPTH];
	logic [smm_pkg::WORD_W-1:0] mem_b [DEPTH];
	logic [smm_pkg::WORD_W-1:0] a_rd_s1;
	logic [smm_pkg::WORD_W-1:0] b_rd_s1;
	logic                       vld_s1;
	logic [2*smm_pkg::WORD_W-1:0] mul_full;
	logic [smm_pkg::WORD_W-1:0] mul_s2;
	logic                       vld_s2;
	logic [smm_pkg::WORD_W-1:0] acc_q;
	logic [smm_pkg::WORD_W-1:0] result_q;
	logic                       bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= smm_pkg::DIM_RESET;
		end else if (dimension_we) begin
			dim_q <= dimension;
		end
	end

	assign dim_use = (dim_q > DIM_CAP) ? DIM_CAP : dim_q;

	assign status.dim_use  = dim_use;
	assign status.index_ok = (smm_pkg::DIM_W'(row) < dim_use) &&
		(smm_pkg::DIM_W'(col) < dim_use);

	assign wr_addr   = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
	assign rd_addr_a = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.step));
	assign rd_addr_b = ADDR_W'(ADDR_W'(cmd.step) * ADDR_W'(MAX_DIM) + ADDR_W'(col_q));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= row;
			col_q <= col;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_a) begin
			mem_a[wr_addr] <= value;
		end
		if (cmd.issue) begin
			a_rd_s1 <= mem_a[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_b) begin
			mem_b[wr_addr] <= value;
		end
		if (cmd.issue) begin
			b_rd_s1 <= mem_b[rd_addr_b];
		end
	end

	// low word of the product is the same for signed and unsigned operands
	assign mul_full = {{smm_pkg::WORD_W{1'b0}}, a_rd_s1} * {{smm_pkg::WORD_W{1'b0}}, b_rd_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2 <= mul_full[smm_pkg::WORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + mul_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q <= acc_q;
			bad_q    <= 1'b0;
		end else if (cmd.load_bad) begin
			result_q <= '0;
			bad_q    <= 1'b1;
		end
	end

	assign product   = result_q;
	assign bad_index = bad_q;

endmodule

// ----- design/smm_ctrl.sv -----
module smm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smm_pkg::CODE_W-1:0]    command,
	input  smm_pkg::dp_status_t           status,
	output smm_pkg::ctrl_cmd_t            cmd,
	output logic                          busy,
	output logic                          done
);

	smm_pkg::state_t            state_q;
	smm_pkg::state_t            state_d;
	logic [smm_pkg::DIM_W-1:0]  step_q;
	logic [smm_pkg::DIM_W-1:0]  step_next;
	logic                       accept;
	logic                       last_step;
	logic                       done_q;

	assign busy      = (state_q != smm_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign step_next = step_q + smm_pkg::DIM_W'(1);
	assign last_step = (step_next == status.dim_use);

	always_comb begin
		state_d = state_q;
		case (state_q)
			smm_pkg::ST_IDLE: begin
				if (accept && command == smm_pkg::CMD_QUERY && status.index_ok) begin
					state_d = smm_pkg::ST_ISSUE;
				end
			end
			smm_pkg::ST_ISSUE: begin
				if (last_step) begin
					state_d = smm_pkg::ST_DRAIN1;
				end
			end
			smm_pkg::ST_DRAIN1: state_d = smm_pkg::ST_DRAIN2;
			smm_pkg::ST_DRAIN2: state_d = smm_pkg::ST_FINISH;
			smm_pkg::ST_FINISH: state_d = smm_pkg::ST_IDLE;
			default:            state_d = smm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		case (state_q)
			smm_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						smm_pkg::CMD_WRITE_A: cmd.write_a = status.index_ok;
						smm_pkg::CMD_WRITE_B: cmd.write_b = status.index_ok;
						smm_pkg::CMD_QUERY: begin
							cmd.capture  = 1'b1;
							cmd.load_bad = !status.index_ok;
						end
						default: ;
					endcase
				end
			end
			smm_pkg::ST_ISSUE:  cmd.issue = 1'b1;
			smm_pkg::ST_FINISH: cmd.load_result = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smm_pkg::ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.load_result || cmd.load_bad;
			// restart the step count on every transaction, advance while issuing
			if (state_q == smm_pkg::ST_ISSUE) begin
				step_q <= step_next;
			end else begin
				step_q <= '0;
			end
		end
	end

	assign done = done_q;

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (step_q < status.dim_use))
		else $error("read step beyond dimension in use");

	a_bad_query_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == smm_pkg::CMD_QUERY && !status.index_ok) |=> (done && !busy))
		else $error("bad query did not strobe a result");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> (done && !busy))
		else $error("finished query did not strobe a result");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(cmd.write_a || cmd.write_b || cmd.capture))
		else $error("transaction taken while busy");

	a_drain_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smm_pkg::ST_DRAIN1) |=> ##1 cmd.load_result)
		else $error("drain did not end in a result load");

endmodule

// ----- design/square_matrix_multiply_unit.sv -----
// Channel   Handshake                Payload
// input     start, busy              command, row, col, value
// config    dimension_we             dimension
// result    done                     product, bad_index
//
// A write does not raise busy, so the next transaction may follow straight away.
// A query in range is busy in ISSUE for n steps, n being the dimension in use,
// then in DRAIN1, DRAIN2, FINISH, and strobes done; the single multiply-accumulate
// path reads one A and one B element per cycle from one read port each.
// A query out of range strobes done with bad_index the cycle after acceptance.
// Reset clears the controller and sets dimension to 8; the matrix stores are
// not cleared. done strobes each result for one cycle; the receiver cannot stall.
module square_matrix_multiply_unit #(
	parameter int MAX_DIM = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [smm_pkg::CODE_W-1:0]         command,
	input  logic [smm_pkg::ROW_W-1:0]          row,
	input  logic [smm_pkg::COL_W-1:0]          col,
	input  logic signed [smm_pkg::WORD_W-1:0]  value,
	input  logic                               dimension_we,
	input  logic [smm_pkg::DIM_W-1:0]          dimension,
	output logic                               done,
	output logic signed [smm_pkg::WORD_W-1:0]  product,
	output logic                               bad_index
);

	smm_pkg::ctrl_cmd_t  cmd;
	smm_pkg::dp_status_t status;

	smm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	smm_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dimension_we (dimension_we),
		.dimension    (dimension),
		.row          (row),
		.col          (col),
		.value        (value),
		.cmd          (cmd),
		.status       (status),
		.product      (product),
		.bad_index    (bad_index)
	);

endmodule

// ----- sim/square_matrix_multiply_unit_tb.sv -----
`timescale 1ns / 100ps

class matrix_product_scoreboard;
	localparam int SIDE = 8;

	typedef struct {
		bit [31:0] product;
		bit        bad_index;
	} entry_t;

	bit [31:0] a_store [SIDE*SIDE];
	bit [31:0] b_store [SIDE*SIDE];
	bit [3:0]  dim_reg;
	entry_t    pending_entries [$];

	int errors;
	int writes;
	int dropped_writes;
	int queries;
	int bad_queries;
	int unused_cmds;

	function new();
		dim_reg = smm_pkg::DIM_RESET;
		errors = 0;
		writes = 0;
		dropped_writes = 0;
		queries = 0;
		bad_queries = 0;
		unused_cmds = 0;
	endfunction

	function void set_dimension(bit [3:0] d);
		dim_reg = d;
	endfunction

	// saturate the register at the store size
	function int unsigned dim_in_force();
		return (dim_reg > SIDE) ? SIDE : dim_reg;
	endfunction

	function bit [31:0] entry_sum(int unsigned r, int unsigned c, int unsigned n);
		bit [31:0] acc;
		acc = 0;
		for (int unsigned t = 0; t < n; t++)
			acc = acc + a_store[r*SIDE+t] * b_store[t*SIDE+c];
		return acc;
	endfunction

	function void note_input(bit [1:0] cmd, bit [2:0] r, bit [2:0] c, bit [31:0] v);
		int unsigned n;
		bit          in_range;
		entry_t      e;
		n = dim_in_force();
		in_range = (r < n) && (c < n);
		case (cmd)
			smm_pkg::CMD_WRITE_A, smm_pkg::CMD_WRITE_B: begin
				if (!in_range) begin
					dropped_writes++;
				end else begin
					writes++;
					if (cmd == smm_pkg::CMD_WRITE_A)
						a_store[r*SIDE+c] = v;
					else
						b_store[r*SIDE+c] = v;
				end
			end
			smm_pkg::CMD_QUERY: begin
				queries++;
				if (in_range) begin
					e.product = entry_sum(r, c, n);
					e.bad_index = 1'b0;
				end else begin
					e.product = '0;
					e.bad_index = 1'b1;
					bad_queries++;
				end
				pending_entries.push_back(e);
			end
			default: unused_cmds++;
		endcase
	endfunction

	function void check_result(logic [31:0] p, logic bad);
		entry_t e;
		if (pending_entries.size() == 0) begin
			errors++;
			$display("%0t: result with no transaction pending: product=%0d bad_index=%b",
				$time, $signed(p), bad);
			return;
		end
		e = pending_entries.pop_front();
		if (p !== e.product) begin
			errors++;
			$display("%0t: product mismatch: expected %0d, actual %0d",
				$time, $signed(e.product), $signed(p));
		end
		if (bad !== e.bad_index) begin
			errors++;
			$display("%0t: bad_index mismatch: expected %b, actual %b",
				$time, e.bad_index, bad);
		end
	endfunction
endclass

module square_matrix_multiply_unit_tb;

	localparam int SIDE = 8;
	localparam logic [smm_pkg::CODE_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [smm_pkg::ROW_W-1:0] LAST_ROW = smm_pkg::ROW_W'(SIDE - 1);
	localparam logic [smm_pkg::COL_W-1:0] LAST_COL = smm_pkg::COL_W'(SIDE - 1);
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1650;
	localparam int PHASE_ITEMS = 150;
	localparam int SETTLE_CYCLES = 16;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic [smm_pkg::CODE_W-1:0]        command = smm_pkg::CMD_WRITE_A;
	logic [smm_pkg::ROW_W-1:0]         row = '0;
	logic [smm_pkg::COL_W-1:0]         col = '0;
	logic signed [smm_pkg::WORD_W-1:0] value = '0;
	logic                              dimension_we = 1'b0;
	logic [smm_pkg::DIM_W-1:0]         dimension = smm_pkg::DIM_RESET;
	logic                              done;
	logic signed [smm_pkg::WORD_W-1:0] product;
	logic                              bad_index;

	int cur_dim = smm_pkg::DIM_RESET;
	int dim_settings = 0;

	matrix_product_scoreboard sb = new();

	square_matrix_multiply_unit #(
		.MAX_DIM(SIDE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.row(row),
		.col(col),
		.value(value),
		.dimension_we(dimension_we),
		.dimension(dimension),
		.done(done),
		.product(product),
		.bad_index(bad_index)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(product, bad_index);
			if (start && !busy)
				sb.note_input(command, row, col, value);
			if (dimension_we)
				sb.set_dimension(dimension);
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Timeout after %0d cycles", LIMIT_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// present one transaction and return at the edge that accepts it, start still high
	task automatic send_item(logic [smm_pkg::CODE_W-1:0] cmd, logic [smm_pkg::ROW_W-1:0] r,
		logic [smm_pkg::COL_W-1:0] c, logic [smm_pkg::WORD_W-1:0] v);
		command <= cmd;
		row <= r;
		col <= c;
		value <= v;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every query has answered, then let the pipeline settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dimension(logic [smm_pkg::DIM_W-1:0] d);
		dimension_we <= 1'b1;
		dimension <= d;
		cur_dim = d;
		dim_settings++;
		@(posedge clk);
		dimension_we <= 1'b0;
	endtask

	function automatic logic [smm_pkg::WORD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h0;
			4: return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [smm_pkg::DIM_W-1:0] pick_dimension();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return smm_pkg::DIM_W'($urandom_range(SIDE + 1, 15));
			default: return smm_pkg::DIM_W'($urandom_range(1, SIDE));
		endcase
	endfunction

	task automatic random_item();
		int unsigned                n;
		int unsigned                roll;
		logic [smm_pkg::CODE_W-1:0] cmd;
		logic [smm_pkg::ROW_W-1:0]  r;
		logic [smm_pkg::COL_W-1:0]  c;
		n = (cur_dim > SIDE) ? SIDE : cur_dim;
		roll = $urandom_range(0, 99);
		if (roll < 38)
			cmd = smm_pkg::CMD_WRITE_A;
		else if (roll < 70)
			cmd = smm_pkg::CMD_WRITE_B;
		else if (roll < 96)
			cmd = smm_pkg::CMD_QUERY;
		else
			cmd = CMD_UNUSED;
		if (n == 0 || $urandom_range(0, 9) == 0) begin
			r = smm_pkg::ROW_W'($urandom_range(0, SIDE - 1));
			c = smm_pkg::COL_W'($urandom_range(0, SIDE - 1));
		end else begin
			r = smm_pkg::ROW_W'($urandom_range(0, n - 1));
			c = smm_pkg::COL_W'($urandom_range(0, n - 1));
		end
		send_item(cmd, r, c, pick_value());
	endtask

	initial begin
		int sent;
		int in_phase;
		int burst;

		sent = 0;
		in_phase = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores at the reset dimension so no query reads an unwritten element
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				send_item(smm_pkg::CMD_WRITE_A, smm_pkg::ROW_W'(r), smm_pkg::COL_W'(c),
					pick_value());
				send_item(smm_pkg::CMD_WRITE_B, smm_pkg::ROW_W'(r), smm_pkg::COL_W'(c),
					pick_value());
			end
		end

		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_QUERY, LAST_ROW, LAST_COL, '1);
		send_item(smm_pkg::CMD_QUERY, LAST_ROW, smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_WRITE_A, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), 32'h7fff_ffff);
		send_item(smm_pkg::CMD_WRITE_B, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), 32'h8000_0000);
		send_item(smm_pkg::CMD_WRITE_A, LAST_ROW, LAST_COL, 32'hffff_ffff);
		send_item(smm_pkg::CMD_WRITE_B, LAST_ROW, LAST_COL, 32'hffff_ffff);
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_QUERY, LAST_ROW, LAST_COL, '0);
		send_item(CMD_UNUSED, smm_pkg::ROW_W'(5), smm_pkg::COL_W'(2), 32'hdead_beef);
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(3), smm_pkg::COL_W'(4), '0);

		drain();
		set_dimension(smm_pkg::DIM_W'(1));
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(1), smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(0), LAST_COL, '0);
		send_item(smm_pkg::CMD_WRITE_A, smm_pkg::ROW_W'(3), smm_pkg::COL_W'(3), 32'h1234_5678);

		drain();
		set_dimension(smm_pkg::DIM_W'(0));
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_WRITE_B, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), '0);

		// above the store size the dimension saturates; also shows the dropped writes stayed out
		drain();
		set_dimension(smm_pkg::DIM_W'(15));
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(3), smm_pkg::COL_W'(3), '0);
		send_item(smm_pkg::CMD_QUERY, smm_pkg::ROW_W'(0), smm_pkg::COL_W'(0), '0);
		send_item(smm_pkg::CMD_QUERY, LAST_ROW, LAST_COL, '0);

		drain();
		set_dimension(smm_pkg::DIM_W'(SIDE));

		while (sent < RANDOM_ITEMS) begin
			if (in_phase >= PHASE_ITEMS) begin
				drain();
				set_dimension(pick_dimension());
				in_phase = 0;
			end
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				random_item();
				sent++;
				in_phase++;
			end
			case ($urandom_range(0, 15))
				0: drain();
				1, 2, 3, 4: ;
				default: begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			endcase
		end

		drain();
		$display("Covered %0d element writes, %0d out-of-range writes, %0d unused commands",
			sb.writes, sb.dropped_writes, sb.unused_cmds);
		$display("Checked %0d product queries (%0d with bad_index) over %0d dimension settings",
			sb.queries, sb.bad_queries, dim_settings);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
